// ===== design/mcss_pkg.sv =====
// Package for the Markov chain step sampler: shared constants, item kinds,
// configuration register indexes and the sequencer state type.
// No dependencies.
package mcss_pkg;

  localparam int MAX_STATES_DEF = 8;
  localparam int PROB_BITS_DEF  = 16;

  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_NUM_W  = 4;
  localparam int STEPS_W    = 32;
  localparam int DWELL_W    = 32;

  localparam logic [CFG_NUM_W-1:0] NUM_STATES_RST = CFG_NUM_W'(2);
  localparam logic [STEPS_W-1:0]   STEPS_RST      = STEPS_W'(1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_INC,
    ST_EMIT_RD,
    ST_EMIT_WR
  } seq_state_t;

endpackage

// ===== design/markov_chain_step_sampler.sv =====
// Markov chain step sampler: top level with the stepping sequencer and the
// dwell counter memory. Depends on mcss_pkg and mcss_tbl_ram.
//
// A load transaction writes one transition table entry and a start
// transaction sets the chain state. A step transaction walks the current
// state's table row one column per cycle through the single read port of
// the table memory, visiting columns until the cumulative sum reaches the
// random value (1 to n columns): the first read is issued while idle, then
// come the column compares and a read-modify-write of the dwell counter.
// The step that closes a window then reads out the n dwell counters one
// result at a time, each a read and then an output load, which waits while
// the output side stalls. A finished result waits in the output register
// while new input transactions are taken, so the input side only waits
// while a step or a read-out is in progress. There is no clearing pass
// after reset: the dwell counters carry one valid bit each, which reset, a
// start or a window end clears.
module markov_chain_step_sampler #(
  parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
  parameter int PROB_BITS  = mcss_pkg::PROB_BITS_DEF,
  localparam int STATE_W   = $clog2(MAX_STATES)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcss_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcss_pkg::KIND_W-1:0]      in_kind,
  input  logic [STATE_W-1:0]               in_row,
  input  logic [STATE_W-1:0]               in_column,
  input  logic [PROB_BITS:0]               in_probability,
  input  logic [PROB_BITS-1:0]             in_random_value,
  input  logic [STATE_W-1:0]               in_start_state,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [STATE_W-1:0]               out_state_index,
  output logic [mcss_pkg::DWELL_W-1:0]     out_dwell_count,
  output logic                             out_range_fault,
  output logic                             out_last
);

  localparam int PROB_W = PROB_BITS + 1;
  localparam int ADDR_W = 2 * STATE_W;
  // A whole row of entries, each below two, summed without overflow.
  localparam int CUM_W  = PROB_W + STATE_W;
  localparam int CNT_W  = $clog2(MAX_STATES + 1);
  localparam int CMP_W  = (CNT_W > mcss_pkg::CFG_NUM_W) ? CNT_W : mcss_pkg::CFG_NUM_W;
  localparam int DW_W   = mcss_pkg::DWELL_W;
  localparam int SW_W   = mcss_pkg::STEPS_W;

  // Registers.
  mcss_pkg::seq_state_t             state_r, state_nxt;
  logic [mcss_pkg::CFG_NUM_W-1:0]   num_states_r;
  logic [SW_W-1:0]                  steps_r;
  logic [STATE_W-1:0]               current_r, current_nxt;
  logic [SW_W-1:0]                  step_cnt_r, step_cnt_nxt;
  logic                             fault_r, fault_nxt;
  logic [MAX_STATES-1:0]            dw_vld_r, dw_vld_nxt;
  logic [STATE_W-1:0]               emit_idx_r, emit_idx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  // Payload registers.
  logic [STATE_W-1:0]               from_r;
  logic [STATE_W-1:0]               col_r, col_nxt;
  logic [CUM_W-1:0]                 cum_r, cum_nxt;
  logic [PROB_BITS-1:0]             rnd_r;
  logic [STATE_W-1:0]               out_state_index_r;
  logic [DW_W-1:0]                  out_dwell_count_r;
  logic                             out_range_fault_r;
  logic                             out_last_r;

  // Dwell counter memory.
  logic [DW_W-1:0]                  dw_mem [MAX_STATES];
  logic [DW_W-1:0]                  dw_q_r;
  logic [STATE_W-1:0]               dw_raddr;
  logic                             dw_we;
  logic [DW_W-1:0]                  dw_count;

  // Table memory interface.
  logic                             tbl_we;
  logic [ADDR_W-1:0]                tbl_raddr;
  logic [PROB_W-1:0]                tbl_rdata;

  // Decoded controls.
  logic                             in_fire;
  logic                             emit_load;
  logic [CMP_W-1:0]                 num_ext;
  logic [CMP_W-1:0]                 n_w;
  logic [STATE_W-1:0]               n_last;
  logic [STATE_W-1:0]               cur_clamp;
  logic [STATE_W-1:0]               start_clamp;
  logic [SW_W-1:0]                  limit;
  logic [SW_W-1:0]                  step_cnt_inc;
  logic [CUM_W-1:0]                 cum_sum;
  logic                             hit;
  logic                             last_col;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == mcss_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Effective number of states: the register clamped into 2..MAX_STATES.
  always_comb begin
    num_ext = CMP_W'(num_states_r);
    if (num_ext < CMP_W'(2)) begin
      n_w = CMP_W'(2);
    end else if (num_ext > CMP_W'(MAX_STATES)) begin
      n_w = CMP_W'(MAX_STATES);
    end else begin
      n_w = num_ext;
    end
    n_last = STATE_W'(n_w - CMP_W'(1));
    cur_clamp   = (CMP_W'(current_r) < n_w) ? current_r : n_last;
    start_clamp = (CMP_W'(in_start_state) < n_w) ? in_start_state : n_last;
  end

  assign limit        = (steps_r == '0) ? SW_W'(1) : steps_r;
  assign step_cnt_inc = step_cnt_r + SW_W'(1);

  // Row walk: the entry for col_r arrives from the table this cycle.
  assign cum_sum  = cum_r + CUM_W'(tbl_rdata);
  assign hit      = (CUM_W'(rnd_r) <= cum_sum);
  assign last_col = (col_r == n_last);

  // The first column is read while idle so a step finds it ready; during the
  // walk the following column is fetched ahead of the compare.
  assign tbl_raddr = (state_r == mcss_pkg::ST_WALK) ?
                     {from_r, STATE_W'(col_r + STATE_W'(1))} :
                     {cur_clamp, {STATE_W{1'b0}}};
  assign tbl_we    = in_fire && (in_kind == mcss_pkg::KIND_LOAD);

  mcss_tbl_ram #(
    .DATA_W (PROB_W),
    .ADDR_W (ADDR_W)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr ({in_row, in_column}),
    .wr_data (in_probability),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // A step ends its walk at col_r whether it hit or ran off the row, so the
  // dwell counter of col_r is read in that same cycle. The sequencer keeps
  // every read-modify-write apart from the next access, so no forwarding is
  // needed on this memory.
  assign dw_raddr  = (state_r == mcss_pkg::ST_WALK) ? col_r : emit_idx_r;
  assign dw_we     = (state_r == mcss_pkg::ST_INC);
  assign dw_count  = dw_vld_r[dw_raddr] ? dw_q_r : '0;
  assign emit_load = (state_r == mcss_pkg::ST_EMIT_WR) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (dw_we) begin
      dw_mem[current_r] <= (dw_vld_r[current_r] ? dw_q_r : '0) + DW_W'(1);
    end
    dw_q_r <= dw_mem[dw_raddr];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    current_nxt   = current_r;
    step_cnt_nxt  = step_cnt_r;
    fault_nxt     = fault_r;
    dw_vld_nxt    = dw_vld_r;
    emit_idx_nxt  = emit_idx_r;
    col_nxt       = col_r;
    cum_nxt       = cum_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mcss_pkg::ST_IDLE: begin
        col_nxt = '0;
        cum_nxt = '0;
        if (in_fire) begin
          unique case (in_kind)
            mcss_pkg::KIND_START: begin
              current_nxt  = start_clamp;
              step_cnt_nxt = '0;
              fault_nxt    = 1'b0;
              dw_vld_nxt   = '0;
            end
            mcss_pkg::KIND_STEP: begin
              state_nxt = mcss_pkg::ST_WALK;
            end
            default: begin
              // Loads go straight to the table; the spare code does nothing.
            end
          endcase
        end
      end
      mcss_pkg::ST_WALK: begin
        cum_nxt = cum_sum;
        if (hit || last_col) begin
          // Running off the row lands in the last state and marks the window.
          if (!hit) begin
            fault_nxt = 1'b1;
          end
          current_nxt = col_r;
          state_nxt   = mcss_pkg::ST_INC;
        end else begin
          col_nxt = STATE_W'(col_r + STATE_W'(1));
        end
      end
      mcss_pkg::ST_INC: begin
        dw_vld_nxt[current_r] = 1'b1;
        step_cnt_nxt = step_cnt_inc;
        emit_idx_nxt = '0;
        state_nxt    = (step_cnt_inc >= limit) ? mcss_pkg::ST_EMIT_RD : mcss_pkg::ST_IDLE;
      end
      mcss_pkg::ST_EMIT_RD: begin
        state_nxt = mcss_pkg::ST_EMIT_WR;
      end
      mcss_pkg::ST_EMIT_WR: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          if (emit_idx_r == n_last) begin
            step_cnt_nxt = '0;
            fault_nxt    = 1'b0;
            dw_vld_nxt   = '0;
            state_nxt    = mcss_pkg::ST_IDLE;
          end else begin
            emit_idx_nxt = STATE_W'(emit_idx_r + STATE_W'(1));
            state_nxt    = mcss_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = mcss_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mcss_pkg::ST_IDLE;
      num_states_r <= mcss_pkg::NUM_STATES_RST;
      steps_r      <= mcss_pkg::STEPS_RST;
      current_r    <= '0;
      step_cnt_r   <= '0;
      fault_r      <= 1'b0;
      dw_vld_r     <= '0;
      emit_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      current_r   <= current_nxt;
      step_cnt_r  <= step_cnt_nxt;
      fault_r     <= fault_nxt;
      dw_vld_r    <= dw_vld_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mcss_pkg::CFG_NUM_STATES: num_states_r <= cfg_data[mcss_pkg::CFG_NUM_W-1:0];
          mcss_pkg::CFG_STEPS:      steps_r      <= cfg_data[SW_W-1:0];
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    cum_r <= cum_nxt;
    if (in_fire) begin
      from_r <= cur_clamp;
      rnd_r  <= in_random_value;
    end
    if (emit_load) begin
      out_state_index_r <= emit_idx_r;
      out_dwell_count_r <= dw_count;
      out_range_fault_r <= fault_r;
      out_last_r        <= (emit_idx_r == n_last);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_state_index = out_state_index_r;
  assign out_dwell_count = out_dwell_count_r;
  assign out_range_fault = out_range_fault_r;
  assign out_last        = out_last_r;

endmodule

// ===== design/mcss_tbl_ram.sv =====
// Transition table storage: one write port, one read port, registered read
// data. Depends on nothing.
module mcss_tbl_ram #(
  parameter int DATA_W = 17,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/mcss_chk.sv =====
// Port-level checker for the Markov chain step sampler, bound to the top
// level. Depends on mcss_pkg.
module mcss_chk #(
  parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
  localparam int STATE_W   = $clog2(MAX_STATES)
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [STATE_W-1:0]           out_state_index,
  input logic [mcss_pkg::DWELL_W-1:0] out_dwell_count,
  input logic                         out_range_fault,
  input logic                         out_last
);

  logic [STATE_W-1:0] exp_idx_r;
  logic               win_fault_r;

  // Track the state index due next and the fault flag of the current window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r   <= '0;
      win_fault_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      exp_idx_r   <= out_last ? '0 : STATE_W'(out_state_index + STATE_W'(1));
      win_fault_r <= out_range_fault;
    end
  end

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_state_index) &&
      $stable(out_dwell_count) && $stable(out_range_fault) && $stable(out_last))
    else $error("result changed while stalled");

  // Results of a window come in state order from state zero.
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_state_index == exp_idx_r)
    else $error("result state index out of order");

  // All results of one window carry the same fault flag.
  a_fault_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && exp_idx_r != '0 |-> out_range_fault == win_fault_r)
    else $error("fault flag changed within a window");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind markov_chain_step_sampler mcss_chk #(
  .MAX_STATES (MAX_STATES)
) u_mcss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_state_index (out_state_index),
  .out_dwell_count (out_dwell_count),
  .out_range_fault (out_range_fault),
  .out_last        (out_last)
);

// ===== bench/tb_markov_chain_step_sampler.sv =====
// Self-checking testbench for markov_chain_step_sampler: a transaction-level
// predictor of the chain, directed and random stimulus with random idling.
// Depends on mcss_pkg and the markov_chain_step_sampler RTL.
module tb_markov_chain_step_sampler;

  localparam int TBL_COLS       = mcss_pkg::MAX_STATES_DEF;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTED   = 10;
  localparam int RANDOM_ITEMS   = 200;

  // Kind code 3 has no meaning in the block; it must be ignored.
  localparam logic [mcss_pkg::KIND_W-1:0] KIND_RSVD = 2'd3;
  // Register indexes that map to nothing.
  localparam logic [mcss_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [mcss_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  typedef struct packed {
    logic [2:0]  state_index;
    logic [31:0] dwell_count;
    logic        range_fault;
    logic        last;
  } dwell_report_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mcss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mcss_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [mcss_pkg::KIND_W-1:0]     in_kind;
  logic [2:0]                      in_row;
  logic [2:0]                      in_column;
  logic [16:0]                     in_probability;
  logic [15:0]                     in_random_value;
  logic [2:0]                      in_start_state;
  logic                            out_valid;
  logic                            out_ready;
  logic [2:0]                      out_state_index;
  logic [mcss_pkg::DWELL_W-1:0]    out_dwell_count;
  logic                            out_range_fault;
  logic                            out_last;

  markov_chain_step_sampler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_probability  (in_probability),
    .in_random_value (in_random_value),
    .in_start_state  (in_start_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_state_index (out_state_index),
    .out_dwell_count (out_dwell_count),
    .out_range_fault (out_range_fault),
    .out_last        (out_last)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor of the chain. It is updated once per accepted transaction, in
  // the order of acceptance, and it pushes the dwell reports that a closing
  // step produces onto the queue of reports still due from the block.
  // ---------------------------------------------------------------------------
  logic [16:0]   prob_tbl [TBL_COLS*TBL_COLS];
  bit            tbl_written [TBL_COLS*TBL_COLS];
  logic [2:0]    chain_state;
  logic [31:0]   dwell_ref [TBL_COLS];
  logic [31:0]   steps_done;
  bit            fault_seen;
  logic [3:0]    cfg_states;
  logic [31:0]   cfg_window;
  dwell_report_t reports_due [$];

  // Effective number of states: the register is clamped to 2..MAX_STATES.
  function automatic int states_in_use();
    int n;
    n = int'(cfg_states);
    if (n < 2) n = 2;
    if (n > TBL_COLS) n = TBL_COLS;
    return n;
  endfunction

  // The row walked by a step is that of the chain state, clamped below n.
  function automatic int walk_row();
    int n;
    n = states_in_use();
    return (chain_state < n) ? int'(chain_state) : n - 1;
  endfunction

  function automatic void clear_window();
    for (int s = 0; s < TBL_COLS; s++) dwell_ref[s] = '0;
    steps_done = '0;
    fault_seen = 1'b0;
  endfunction

  function automatic void reset_chain_model();
    for (int i = 0; i < TBL_COLS*TBL_COLS; i++) begin
      prob_tbl[i]    = '0;
      tbl_written[i] = 1'b0;
    end
    chain_state = '0;
    cfg_states  = mcss_pkg::NUM_STATES_RST;
    cfg_window  = mcss_pkg::STEPS_RST;
    clear_window();
  endfunction

  function automatic void apply_register(input logic [mcss_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [mcss_pkg::CFG_DATA_W-1:0] data);
    if (idx == mcss_pkg::CFG_NUM_STATES) cfg_states = data[3:0];
    else if (idx == mcss_pkg::CFG_STEPS) cfg_window = data;
  endfunction

  function automatic void predict_transaction(input logic [mcss_pkg::KIND_W-1:0] kind,
                                              input logic [2:0] row,
                                              input logic [2:0] column,
                                              input logic [16:0] prob,
                                              input logic [15:0] rnd,
                                              input logic [2:0] start);
    int            n;
    int            from;
    int            next;
    logic [31:0]   cum;
    logic [31:0]   limit;
    bit            hit;
    dwell_report_t rep;
    n = states_in_use();
    case (kind)
      mcss_pkg::KIND_LOAD: begin
        prob_tbl[row*TBL_COLS + column]    = prob;
        tbl_written[row*TBL_COLS + column] = 1'b1;
      end
      mcss_pkg::KIND_START: begin
        chain_state = (start < n) ? start : 3'(n - 1);
        clear_window();
      end
      mcss_pkg::KIND_STEP: begin
        from = walk_row();
        cum  = '0;
        next = n - 1;
        hit  = 1'b0;
        // Inverse-CDF pick: first column whose running sum reaches the value.
        for (int s = 0; s < n; s++) begin
          if (!hit) begin
            cum += 32'(prob_tbl[from*TBL_COLS + s]);
            if (32'(rnd) <= cum) begin
              next = s;
              hit  = 1'b1;
            end
          end
        end
        if (!hit) fault_seen = 1'b1;
        chain_state = 3'(next);
        dwell_ref[next] += 1;
        steps_done += 1;
        limit = (cfg_window == 0) ? 32'd1 : cfg_window;
        if (steps_done >= limit) begin
          for (int s = 0; s < n; s++) begin
            rep.state_index = 3'(s);
            rep.dwell_count = dwell_ref[s];
            rep.range_fault = fault_seen;
            rep.last        = (s == n - 1);
            reports_due.push_back(rep);
          end
          clear_window();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length separated by random gaps,
  // unless gaps are switched off for a stretch. Valid stays high between
  // back-to-back transactions; it is only lowered for a gap or a pause.
  // ---------------------------------------------------------------------------
  bit gaps_on;
  int burst_left;
  int items_sent;

  task automatic send_item(input logic [mcss_pkg::KIND_W-1:0] kind,
                           input logic [2:0] row,
                           input logic [2:0] column, input logic [16:0] prob,
                           input logic [15:0] rnd, input logic [2:0] start);
    int gap;
    gap = 0;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_row          <= row;
    in_column       <= column;
    in_probability  <= prob;
    in_random_value <= rnd;
    in_start_state  <= start;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (burst_left > 0) burst_left--;
    if (kind != KIND_RSVD) items_sent++;
    predict_transaction(kind, row, column, prob, rnd, start);
  endtask

  // Fields that the kind does not use still carry random values.
  task automatic send_load(input logic [2:0] row, input logic [2:0] column,
                           input logic [16:0] prob);
    send_item(mcss_pkg::KIND_LOAD, row, column, prob, 16'($urandom), 3'($urandom));
  endtask

  task automatic send_start(input logic [2:0] start);
    send_item(mcss_pkg::KIND_START, 3'($urandom), 3'($urandom), 17'($urandom),
              16'($urandom), start);
  endtask

  task automatic send_noise();
    send_item(KIND_RSVD, 3'($urandom), 3'($urandom), 17'($urandom), 16'($urandom),
              3'($urandom));
  endtask

  function automatic logic [16:0] pick_probability();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 17'd0;
      1:       return 17'h10000;
      2:       return 17'($urandom);   // anything the field holds, above one too
      default: return 17'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic logic [15:0] pick_random_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A table entry that was never loaded must not be read. Walk the row just
  // as the block will for this value and load whatever it would touch first.
  task automatic ensure_reads_defined(input logic [15:0] rnd);
    int          n;
    int          from;
    logic [31:0] cum;
    n    = states_in_use();
    from = walk_row();
    cum  = '0;
    for (int c = 0; c < n; c++) begin
      if (!tbl_written[from*TBL_COLS + c]) send_load(3'(from), 3'(c), pick_probability());
      cum += 32'(prob_tbl[from*TBL_COLS + c]);
      if (32'(rnd) <= cum) break;
    end
  endtask

  task automatic send_step(input logic [15:0] rnd);
    ensure_reads_defined(rnd);
    send_item(mcss_pkg::KIND_STEP, 3'($urandom), 3'($urandom), 17'($urandom), rnd,
              3'($urandom));
  endtask

  // Loads a whole row. A well-formed row sums to one over the states in use;
  // otherwise entries are random and the row may fall short or overshoot.
  task automatic load_row(input logic [2:0] row, input bit well_formed);
    int          n;
    logic [16:0] rest;
    logic [16:0] p;
    n    = states_in_use();
    rest = 17'h10000;
    for (int c = 0; c < TBL_COLS; c++) begin
      if (!well_formed || c >= n) p = pick_probability();
      else if (c == n - 1) p = rest;
      else p = 17'($urandom_range(0, rest));
      if (well_formed && c < n) rest -= p;
      send_load(row, 3'(c), p);
    end
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
  endtask

  // Registers are only written once every report due has arrived and any
  // step that closes no window has had time to finish its row walk.
  task automatic write_register(input logic [mcss_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mcss_pkg::CFG_DATA_W-1:0] data);
    pause_input();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The upper bits of the state-count write carry noise; only four bits count.
  task automatic set_window_config(input logic [3:0] states, input logic [31:0] steps);
    write_register(mcss_pkg::CFG_NUM_STATES, ($urandom & 32'hFFFF_FFF0) | 32'(states));
    write_register(mcss_pkg::CFG_STEPS, steps);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. out_ready follows a random mode, picked anew after a random stretch:
  // always ready, a repeating random stall pattern, or sparse acceptance.
  // A test can ask for a long hold-off, counted here.
  // ---------------------------------------------------------------------------
  int         hold_req;
  int         hold_left;
  int         ready_mode;
  int         mode_left;
  int         ready_phase;
  logic [7:0] ready_mask;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_mask = 8'($urandom) | 8'h01;
        mode_left  = $urandom_range(16, 64);
      end
      mode_left--;
      ready_phase = (ready_phase + 1) % 8;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ready_mask[ready_phase];
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // report due. Only the first few failures are described in full.
  // ---------------------------------------------------------------------------
  int            error_count;
  dwell_report_t report_seen;
  dwell_report_t report_want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      report_seen = '{out_state_index, out_dwell_count, out_range_fault, out_last};
      if (reports_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTED)
          $display("unexpected result: state %0d count %0d fault %0b last %0b",
                   report_seen.state_index, report_seen.dwell_count,
                   report_seen.range_fault, report_seen.last);
      end else begin
        report_want = reports_due.pop_front();
        if (report_seen !== report_want) begin
          error_count++;
          if (error_count <= MAX_REPORTED) begin
            $display("mismatch: expected state %0d count %0d fault %0b last %0b",
                     report_want.state_index, report_want.dwell_count,
                     report_want.range_fault, report_want.last);
            $display("          got state %0d count %0d fault %0b last %0b",
                     report_seen.state_index, report_seen.dwell_count,
                     report_seen.range_fault, report_seen.last);
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles without any transaction means a hang.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
               quiet_cycles, reports_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: two states and one step per window, so every step reports
  // both states. Covers exact hits on a cumulative boundary, the smallest and
  // largest random values, a zero entry, and a row that falls short.
  task automatic test_reset_defaults();
    send_load(3'd0, 3'd0, 17'd30000);
    send_load(3'd0, 3'd1, 17'd35536);
    send_load(3'd1, 3'd0, 17'd0);
    send_load(3'd1, 3'd1, 17'd20000);
    send_step(16'd30000);   // lands exactly on the first boundary
    send_step(16'd30001);   // just past it, so the chain moves to state 1
    send_step(16'd0);       // zero entry still catches a zero value
    send_step(16'd30001);
    send_step(16'hFFFF);    // row 1 sums to 20000: short, fault flagged
    send_step(16'd20000);
  endtask

  // Clamped register values, a zero window length, start states beyond the
  // states in use, entries above one, a start in mid-window, ignored kinds
  // and writes to register indexes that map to nothing.
  task automatic test_special_cases();
    set_window_config(4'd0, 32'd0);
    send_step(16'hFFFF);
    send_noise();
    set_window_config(4'd15, 32'd3);
    send_load(3'd6, 3'd0, 17'h1FFFF);
    send_start(3'd6);
    send_step(16'hFFFF);    // oversized entry: caught in column 0
    send_step(16'd0);
    send_start(3'd6);       // throws the partial window away
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'd0);
    write_register(CFG_UNMAPPED_A, 32'($urandom));
    write_register(CFG_UNMAPPED_B, 32'($urandom));
    set_window_config(4'd1, 32'd3);
    send_start(3'd5);       // beyond the two states in use: clamps to 1
    send_noise();
    send_step(16'd0);
    send_step(16'hFFFF);
    send_step(16'd12345);
  endtask

  // Random windows: each phase picks a setting, reloads some rows (most of them
  // well-formed) and then runs windows with random values, mixed with stray starts,
  // single loads and ignored items.
  task automatic test_random_windows();
    int  base;
    int  sel;
    int  window;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      sel    = $urandom_range(0, 3);
      window = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      set_window_config((sel == 0) ? 4'd2 : (sel == 1) ? 4'd8 : 4'($urandom),
                        32'(window));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3))
        load_row(3'($urandom), $urandom_range(0, 2) != 0);
      send_start(3'($urandom));
      repeat ($urandom_range(8, 30)) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) send_noise();
        else if (sel == 1) send_start(3'($urandom));
        else if (sel == 2) send_load(3'($urandom), 3'($urandom), pick_probability());
        else send_step(pick_random_value());
      end
    end
    gaps_on = 1'b1;
  endtask

  // Longest window: the counters run but no window closes.
  task automatic test_long_window();
    set_window_config(4'($urandom_range(2, 8)), 32'hFFFF_FFFF);
    send_start(3'($urandom));
    repeat (20) send_step(pick_random_value());
    send_start(3'($urandom));
  endtask

  // The receiver holds off for a long stretch while steps keep coming, each
  // closing a window of eight reports, so the block backs up and stalls.
  task automatic test_output_backpressure();
    set_window_config(4'd8, 32'd1);
    gaps_on  = 1'b0;
    hold_req = HOLD_CYCLES;
    send_start(3'd0);
    repeat (30) send_step(pick_random_value());
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_kind         = mcss_pkg::KIND_LOAD;
    in_row          = '0;
    in_column       = '0;
    in_probability  = '0;
    in_random_value = '0;
    in_start_state  = '0;
    out_ready       = 1'b1;
    gaps_on         = 1'b1;
    burst_left      = 0;
    items_sent      = 0;
    hold_req        = 0;
    hold_left       = 0;
    mode_left       = 0;
    ready_phase     = 0;
    error_count     = 0;
    quiet_cycles    = 0;
    reset_chain_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_random_windows();
    test_long_window();
    test_output_backpressure();

    // Drain: the watchdog covers a block that never delivers the rest.
    pause_input();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && reports_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== markov_chain_step_sampler.f =====
design/mcss_pkg.sv
design/mcss_tbl_ram.sv
design/markov_chain_step_sampler.sv
design/mcss_chk.sv
bench/tb_markov_chain_step_sampler.sv
